// File: hw/rtl/bfds_pkg.sv
package bfds_pkg;

  // Counter value left behind when a transfer ends
  localparam logic [15:0] FINISHED_MARK = 16'hFFFF;

  typedef enum logic [2:0] {
    STATUS_INITIATING  = 3'd0,
    STATUS_READY_NEXT  = 3'd1,
    STATUS_COMPLETE    = 3'd2,
    STATUS_FRAME_ERROR = 3'd3,
    STATUS_WRITE_ERROR = 3'd4
  } status_t;

  typedef enum logic {
    CMD_BEGIN = 1'b0,
    CMD_FRAME = 1'b1
  } command_t;

  typedef struct packed {
    command_t    command;
    logic [7:0]  transfer_id;
    logic [15:0] frame_total;
    logic [15:0] frame_number;
    logic [15:0] byte_count;
    logic        device_done;
    logic        device_init_b;
    logic        link_write_error;
  } item_t;

  typedef struct packed {
    logic [7:0]  active_transfer;
    logic [15:0] total_frames;
    logic [15:0] expected_frame;
    logic        program_level;
  } seq_state_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  reply_transfer_id;
    logic [15:0] reply_frame;
    logic [15:0] reply_bytes;
    logic        forward_frame;
    logic        program_line;
    logic        reset_all;
  } result_t;

endpackage

// File: hw/rtl/bfds_step.sv
module bfds_step (
  input  bfds_pkg::item_t      item,
  input  bfds_pkg::seq_state_t state,
  output bfds_pkg::seq_state_t state_next,
  output bfds_pkg::result_t    result,
  output logic                 has_result
);

  logic            id_match;
  logic            in_order;
  logic            last_frame;
  logic            device_fail;
  logic            ends;
  logic [16:0]     expected_plus;
  bfds_pkg::status_t status;

  assign id_match      = (item.transfer_id == state.active_transfer);
  assign in_order      = (item.frame_number == state.expected_frame);
  assign expected_plus = {1'b0, state.expected_frame} + 17'd1;
  assign last_frame    = !(expected_plus < {1'b0, state.total_frames});
  assign device_fail   = item.device_done && !item.device_init_b;
  // Device failure masks the link error: the transfer keeps going
  assign ends = (!device_fail && item.link_write_error) ||
                (!device_fail && in_order && last_frame);

  always_comb begin
    priority if (device_fail || item.link_write_error) begin
      status = bfds_pkg::STATUS_WRITE_ERROR;
    end else if (!in_order) begin
      status = bfds_pkg::STATUS_FRAME_ERROR;
    end else if (!last_frame) begin
      status = bfds_pkg::STATUS_READY_NEXT;
    end else begin
      status = bfds_pkg::STATUS_COMPLETE;
    end
  end

  always_comb begin
    state_next = state;
    result     = '0;
    has_result = 1'b0;
    unique case (item.command)
      bfds_pkg::CMD_BEGIN: begin
        state_next.active_transfer = item.transfer_id;
        state_next.total_frames    = item.frame_total;
        state_next.expected_frame  = '0;
        state_next.program_level   = 1'b0;
        result.status              = bfds_pkg::STATUS_INITIATING;
        result.reply_transfer_id   = item.transfer_id;
        has_result                 = 1'b1;
      end
      bfds_pkg::CMD_FRAME: begin
        if (id_match) begin
          state_next.program_level  = 1'b1;
          state_next.expected_frame = ends ? bfds_pkg::FINISHED_MARK
                                           : expected_plus[15:0];
          result.status             = status;
          result.reply_transfer_id  = state.active_transfer;
          result.reply_frame        = state.expected_frame;
          result.reply_bytes        = item.byte_count;
          result.forward_frame      = !device_fail;
          result.program_line       = 1'b1;
          result.reset_all          = ends;
          has_result                = 1'b1;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

// File: hw/rtl/bitstream_frame_download_sequencer_core.sv
// Channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// message  | in_valid / in_ready  | command, transfer_id, frame_total,
//          |                      | frame_number, byte_count, device_done,
//          |                      | device_init_b, link_write_error
// reply    | out_valid / out_ready| status, reply_transfer_id, reply_frame,
//          |                      | reply_bytes, forward_frame, program_line,
//          |                      | reset_all
//
// One word per cycle sustained while out_ready holds. A word lands in the
// input register, then one pass of compare/increment logic fills the reply
// register and updates the sequencer state in the same edge.
// Frame words with a foreign transfer id leave the input register with no reply.
// Synchronous reset clears the valid flags and the sequencer state.
// A stalled reply holds both registers; in_ready drops once both are full.
module bitstream_frame_download_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  transfer_id,
  input  logic [15:0] frame_total,
  input  logic [15:0] frame_number,
  input  logic [15:0] byte_count,
  input  logic        device_done,
  input  logic        device_init_b,
  input  logic        link_write_error,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  reply_transfer_id,
  output logic [15:0] reply_frame,
  output logic [15:0] reply_bytes,
  output logic        forward_frame,
  output logic        program_line,
  output logic        reset_all
);

  // Input register
  logic                 item_valid;
  bfds_pkg::item_t      item;

  // Sequencer state
  bfds_pkg::seq_state_t state;
  bfds_pkg::seq_state_t state_next;

  // Reply register
  bfds_pkg::result_t    result;
  bfds_pkg::result_t    result_next;
  logic                 has_result;

  logic                 advance;

  // Move the held word on when the reply slot is free or being emptied
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  bfds_step u_step (
    .item       (item),
    .state      (state),
    .state_next (state_next),
    .result     (result_next),
    .has_result (has_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Payload needs no reset; load only on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.command          <= bfds_pkg::command_t'(command);
      item.transfer_id      <= transfer_id;
      item.frame_total      <= frame_total;
      item.frame_number     <= frame_number;
      item.byte_count       <= byte_count;
      item.device_done      <= device_done;
      item.device_init_b    <= device_init_b;
      item.link_write_error <= link_write_error;
    end
  end

  // Commit state as the word leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      result <= result_next;
    end
  end

  assign status            = result.status;
  assign reply_transfer_id = result.reply_transfer_id;
  assign reply_frame       = result.reply_frame;
  assign reply_bytes       = result.reply_bytes;
  assign forward_frame     = result.forward_frame;
  assign program_line      = result.program_line;
  assign reset_all         = result.reset_all;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

// Mirror of the download sequencer: holds its own copy of the sequencer
// registers and the replies still owed by the block, oldest first.
class reply_tracker;
  bfds_pkg::seq_state_t regs;
  bfds_pkg::result_t    due_replies[$];
  int unsigned          errors;

  function new();
    regs   = '0;
    errors = 0;
  endfunction

  // Advance the mirrored sequencer by one accepted message.
  function void note_message(bfds_pkg::item_t m);
    bfds_pkg::result_t r;
    logic              ends;
    logic [16:0]       next_frame;
    r    = '0;
    ends = 1'b0;
    if (m.command == bfds_pkg::CMD_BEGIN) begin
      regs.active_transfer = m.transfer_id;
      regs.total_frames    = m.frame_total;
      regs.expected_frame  = '0;
      regs.program_level   = 1'b0;
      r.status             = bfds_pkg::STATUS_INITIATING;
      r.reply_transfer_id  = m.transfer_id;
      due_replies.push_back(r);
      return;
    end
    // Drop frames of some other transfer without a reply.
    if (m.transfer_id != regs.active_transfer) return;
    r.reply_frame = regs.expected_frame;
    next_frame    = {1'b0, regs.expected_frame} + 17'd1;
    if (m.frame_number != regs.expected_frame) r.status = bfds_pkg::STATUS_FRAME_ERROR;
    else if (next_frame < {1'b0, regs.total_frames}) r.status = bfds_pkg::STATUS_READY_NEXT;
    else r.status = bfds_pkg::STATUS_COMPLETE;
    regs.program_level = 1'b1;
    if (m.device_done && !m.device_init_b) begin
      // Device failure masks the link error and does not end the transfer.
      r.status        = bfds_pkg::STATUS_WRITE_ERROR;
      r.forward_frame = 1'b0;
    end else begin
      r.forward_frame = 1'b1;
      if (m.link_write_error) begin
        r.status = bfds_pkg::STATUS_WRITE_ERROR;
        ends     = 1'b1;
      end
    end
    if (r.status == bfds_pkg::STATUS_COMPLETE) ends = 1'b1;
    if (ends) regs.expected_frame = bfds_pkg::FINISHED_MARK;
    else regs.expected_frame = regs.expected_frame + 16'd1;
    r.reply_transfer_id = regs.active_transfer;
    r.reply_bytes       = m.byte_count;
    r.program_line      = regs.program_level;
    r.reset_all         = ends;
    due_replies.push_back(r);
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_reply(bfds_pkg::result_t got);
    bfds_pkg::result_t want;
    if (due_replies.size() == 0) begin
      $display("%0t: reply with none expected, status %0h frame %0h",
               $time, got.status, got.reply_frame);
      errors++;
      return;
    end
    want = due_replies.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("reply_transfer_id", want.reply_transfer_id, got.reply_transfer_id);
    compare_field("reply_frame", want.reply_frame, got.reply_frame);
    compare_field("reply_bytes", want.reply_bytes, got.reply_bytes);
    compare_field("forward_frame", want.forward_frame, got.forward_frame);
    compare_field("program_line", want.program_line, got.program_line);
    compare_field("reset_all", want.reset_all, got.reset_all);
  endfunction
endclass

module testbench;

  // Generous bound: every word waiting out both sides' longest idle bursts,
  // the long receiver hold-off and the pipeline, several times over.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEM_COUNT  = 1650;
  localparam int unsigned QUIET_FROM  = 1450;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_LEN    = 300;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [7:0]  transfer_id;
  logic [15:0] frame_total;
  logic [15:0] frame_number;
  logic [15:0] byte_count;
  logic        device_done;
  logic        device_init_b;
  logic        link_write_error;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [7:0]  reply_transfer_id;
  logic [15:0] reply_frame;
  logic [15:0] reply_bytes;
  logic        forward_frame;
  logic        program_line;
  logic        reset_all;

  reply_tracker tracker;
  int unsigned  cycle_count;
  int unsigned  words_sent;
  logic         quiet;

  bitstream_frame_download_sequencer_core dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .transfer_id      (transfer_id),
    .frame_total      (frame_total),
    .frame_number     (frame_number),
    .byte_count       (byte_count),
    .device_done      (device_done),
    .device_init_b    (device_init_b),
    .link_write_error (link_write_error),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .reply_transfer_id(reply_transfer_id),
    .reply_frame      (reply_frame),
    .reply_bytes      (reply_bytes),
    .forward_frame    (forward_frame),
    .program_line     (program_line),
    .reset_all        (reset_all)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bitstream_frame_download_sequencer_core: mismatch");
      $finish;
    end
  end

  // Sample both channels at the rising edge. Check the reply first: with a
  // registered reply path, a word accepted at this edge cannot own it.
  always @(posedge clk) begin
    bfds_pkg::item_t   m;
    bfds_pkg::result_t r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        r.status            = bfds_pkg::status_t'(status);
        r.reply_transfer_id = reply_transfer_id;
        r.reply_frame       = reply_frame;
        r.reply_bytes       = reply_bytes;
        r.forward_frame     = forward_frame;
        r.program_line      = program_line;
        r.reset_all         = reset_all;
        tracker.check_reply(r);
      end
      if (in_valid && in_ready) begin
        m.command          = bfds_pkg::command_t'(command);
        m.transfer_id      = transfer_id;
        m.frame_total      = frame_total;
        m.frame_number     = frame_number;
        m.byte_count       = byte_count;
        m.device_done      = device_done;
        m.device_init_b    = device_init_b;
        m.link_write_error = link_write_error;
        tracker.note_message(m);
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off once the sender is well
  // underway so the block backs up into its input, and no stalls at the end.
  initial begin
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      if (!held && words_sent >= HOLD_AT) begin
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offer one word and hold it until accepted; then maybe idle a burst.
  task automatic send_message(input bfds_pkg::item_t m);
    @(negedge clk);
    in_valid         = 1'b1;
    command          = m.command;
    transfer_id      = m.transfer_id;
    frame_total      = m.frame_total;
    frame_number     = m.frame_number;
    byte_count       = m.byte_count;
    device_done      = m.device_done;
    device_init_b    = m.device_init_b;
    link_write_error = m.link_write_error;
    do @(posedge clk); while (!in_ready);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
  endtask

  task automatic send_begin(input logic [7:0] tid, input logic [15:0] total);
    bfds_pkg::item_t m;
    m             = '0;
    m.command     = bfds_pkg::CMD_BEGIN;
    m.transfer_id = tid;
    m.frame_total = total;
    send_message(m);
    words_sent++;
  endtask

  // Pin order: done, init_b, link error.
  task automatic send_frame(input logic [7:0] tid, input logic [15:0] fnum,
                            input logic [15:0] bytes, input logic [2:0] pins);
    bfds_pkg::item_t m;
    m                  = '0;
    m.command          = bfds_pkg::CMD_FRAME;
    m.transfer_id      = tid;
    m.frame_number     = fnum;
    m.byte_count       = bytes;
    m.device_done      = pins[2];
    m.device_init_b    = pins[1];
    m.link_write_error = pins[0];
    send_message(m);
    words_sent++;
  endtask

  // One well-formed transfer with random content and occasional faults:
  // wrong frame numbers, device failure, link errors, foreign frames.
  task automatic run_transfer();
    logic [7:0]  tid;
    logic [15:0] total;
    logic [15:0] ix;
    logic [15:0] fnum;
    logic [2:0]  pins;
    int unsigned n_frames;
    int unsigned k;
    bit          ends;
    tid = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       total = 16'd0;
      1:       total = 16'($urandom_range(0, 65535));
      2:       total = 16'hFFFF;
      default: total = 16'($urandom_range(1, 12));
    endcase
    send_begin(tid, total);
    n_frames = (total >= 1 && total <= 12) ? total + $urandom_range(0, 2)
                                           : $urandom_range(1, 16);
    ix = 16'd0;
    for (k = 0; k < n_frames; k++) begin
      pins = 3'b010;
      case ($urandom_range(0, 19))
        0: pins = 3'b001;
        1: pins = {2'b10, 1'($urandom_range(0, 1))};
        2: pins = {2'($urandom_range(0, 3)), 1'b0};
        default: ;
      endcase
      fnum = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535)) : ix;
      if ($urandom_range(0, 19) == 0) begin
        // Foreign transfer id: ignored, counter holds.
        send_frame(tid ^ 8'($urandom_range(1, 255)), fnum,
                   16'($urandom_range(0, 65535)), pins);
      end else begin
        send_frame(tid, fnum, 16'($urandom_range(0, 65535)), pins);
        if (pins[2] && !pins[1]) begin
          ends = 1'b0;
        end else begin
          ends = pins[0] ||
                 (fnum == ix && ({1'b0, ix} + 17'd1) >= {1'b0, total});
        end
        ix = ends ? bfds_pkg::FINISHED_MARK : ix + 16'd1;
        // Usually stop at the end of the transfer; sometimes keep poking it.
        if (ends && $urandom_range(0, 3) != 0) break;
      end
    end
  endtask

  // Fully random words: random command and every field at random.
  task automatic send_noise();
    bfds_pkg::item_t m;
    m.command          = bfds_pkg::command_t'($urandom_range(0, 1));
    m.transfer_id      = 8'($urandom_range(0, 255));
    m.frame_total      = 16'($urandom_range(0, 65535));
    m.frame_number     = 16'($urandom_range(0, 65535));
    m.byte_count       = 16'($urandom_range(0, 65535));
    m.device_done      = 1'($urandom_range(0, 1));
    m.device_init_b    = 1'($urandom_range(0, 1));
    m.link_write_error = 1'($urandom_range(0, 1));
    send_message(m);
    words_sent++;
  endtask

  initial begin
    tracker          = new();
    cycle_count      = 0;
    words_sent       = 0;
    quiet            = 1'b0;
    rst              = 1'b1;
    in_valid         = 1'b0;
    command          = 1'b0;
    transfer_id      = '0;
    frame_total      = '0;
    frame_number     = '0;
    byte_count       = '0;
    device_done      = 1'b0;
    device_init_b    = 1'b0;
    link_write_error = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Frames before any begin run against the reset state: id 0, total 0.
    send_frame(8'h01, 16'd0, 16'd7, 3'b010);
    send_frame(8'h00, 16'd0, 16'hFFFF, 3'b010);
    // Plain three-frame transfer, then a frame past the finished mark that
    // misses and wraps the counter.
    send_begin(8'hFF, 16'd3);
    send_frame(8'hFF, 16'd0, 16'd0, 3'b010);
    send_frame(8'hFF, 16'd1, 16'h1234, 3'b110);
    send_frame(8'h00, 16'd2, 16'd1, 3'b010);
    send_frame(8'hFF, 16'd2, 16'hABCD, 3'b010);
    send_frame(8'hFF, 16'd2, 16'd5, 3'b010);
    // Full-size transfer: frame error, device failure masking a link error,
    // init_b low alone, link error on a wrong number, frames at the mark.
    send_begin(8'hA5, 16'hFFFF);
    send_frame(8'hA5, 16'd7, 16'd3, 3'b010);
    send_frame(8'hA5, 16'd1, 16'd3, 3'b101);
    send_frame(8'hA5, 16'd2, 16'h8000, 3'b000);
    send_frame(8'hA5, 16'd9, 16'h7FFF, 3'b011);
    send_frame(8'hA5, 16'hFFFF, 16'd1, 3'b010);
    send_frame(8'hA5, 16'hFFFF, 16'd2, 3'b100);
    // Zero frame total: the first in-order frame completes.
    send_begin(8'h00, 16'd0);
    send_frame(8'h00, 16'd0, 16'd9, 3'b010);
    // Single-frame transfer, and a link error on the last frame.
    send_begin(8'h5A, 16'd1);
    send_frame(8'h5A, 16'd0, 16'h5555, 3'b010);
    send_begin(8'h3C, 16'd2);
    send_frame(8'h3C, 16'd0, 16'hAAAA, 3'b010);
    send_frame(8'h3C, 16'd1, 16'd4, 3'b011);

    while (words_sent < ITEM_COUNT) begin
      if (words_sent >= QUIET_FROM) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) send_noise();
      end else begin
        run_transfer();
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.due_replies.size() != 0) @(posedge clk);
    // Let a trailing foreign frame drain through the two-stage pipe.
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("bitstream_frame_download_sequencer_core: match");
    end else begin
      $display("bitstream_frame_download_sequencer_core: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/bfds_pkg.sv
hw/rtl/bfds_step.sv
hw/rtl/bitstream_frame_download_sequencer_core.sv
dv/testbench.sv
